>>> design/ctc_pkg.sv
// shared types and constants of the cosine threshold compare block
`default_nettype none
package ctc_pkg;

  localparam int ELEM_W   = 32;
  localparam int ACC_W    = 76;
  localparam int CFG_W    = 16;
  localparam int LIMB_W   = 32;
  localparam int LIMBS    = 6;
  localparam int B_LIMBS  = 3;
  localparam int MUL_W    = LIMBS * LIMB_W;
  localparam int MULB_W   = B_LIMBS * LIMB_W;
  localparam int LIMB_IW  = 3;
  localparam int ROW_IW   = 2;
  localparam int CFG_IW   = 2;

  localparam logic [CFG_W-1:0] NUM_RESET = 16'd999;
  localparam logic [CFG_W-1:0] DEN_RESET = 16'd1000;

  localparam logic [CFG_IW-1:0] CFG_IDX_NUM  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IDX_DEN  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_IDX_LESS = 2'd2;

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_first;
    logic signed [ELEM_W-1:0] elem_second;
    logic                     last_element;
  } in_beat_t;

  typedef struct packed {
    logic test_true;
    logic zero_norm;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_CHECK,
    ST_LOAD,
    ST_MUL,
    ST_RESULT
  } ctc_state_t;

  // operand loads of the four wide multiplications
  typedef enum logic [1:0] {
    LD_DOT_SQ,
    LD_LHS_K,
    LD_NORMS,
    LD_RHS_K
  } ld_sel_t;

  typedef struct packed {
    logic               in_take;
    logic               acc_clear;
    logic               op_load;
    ld_sel_t            ld_sel;
    logic               mul_en;
    logic               row_start;
    logic [LIMB_IW-1:0] limb_i;
    logic [ROW_IW-1:0]  limb_j;
    logic               out_load;
    logic               out_zero;
  } ctc_cmd_t;

  typedef struct packed {
    logic zero_norm;
  } ctc_sts_t;

endpackage
`default_nettype wire

>>> design/ctc_datapath.sv
// accumulators, limb multiplier, comparator and output register
`default_nettype none
module ctc_datapath import ctc_pkg::*; #(
  parameter int ELEM_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire in_beat_t          in_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire ctc_cmd_t          cmd,
  output ctc_sts_t               sts,
  output out_beat_t              out_data
);

  localparam int PROD_W = 2 * ELEM_BITS;

  logic [CFG_W-1:0] ratio_num_r;
  logic [CFG_W-1:0] ratio_den_r;
  logic             cmp_less_r;

  logic signed [ELEM_BITS-1:0] x;
  logic signed [ELEM_BITS-1:0] y;
  logic signed [PROD_W-1:0]    prod_xy;
  logic signed [PROD_W-1:0]    prod_xx;
  logic signed [PROD_W-1:0]    prod_yy;

  logic [PROD_W-1:0] prod_dot_r;
  logic [PROD_W-1:0] prod_na_r;
  logic [PROD_W-1:0] prod_nb_r;
  logic              prod_vld_r;

  logic [ACC_W-1:0] acc_dot_r;
  logic [ACC_W-1:0] acc_na_r;
  logic [ACC_W-1:0] acc_nb_r;
  logic [ACC_W-1:0] dot_mag;

  logic [MUL_W-1:0]  mul_a_r;
  logic [MULB_W-1:0] mul_b_r;
  logic [MUL_W-1:0]  mul_t_r;
  logic [MUL_W-1:0]  mul_t_nxt;
  logic [MUL_W-1:0]  lhs_r;
  logic [LIMB_W-1:0] carry_r;

  logic [LIMB_IW-1:0]  t_idx;
  logic [LIMB_W-1:0]   a_limb;
  logic [LIMB_W-1:0]   b_limb;
  logic [LIMB_W-1:0]   t_limb;
  logic [LIMB_W-1:0]   carry_in;
  logic [2*LIMB_W-1:0] cur;

  logic [2*CFG_W-1:0] den_sq;
  logic [2*CFG_W-1:0] num_sq;
  logic               lhs_gt;
  logic               lhs_lt;
  out_beat_t          out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_num_r <= NUM_RESET;
      ratio_den_r <= DEN_RESET;
      cmp_less_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_NUM:  ratio_num_r <= cfg_data;
        CFG_IDX_DEN:  ratio_den_r <= cfg_data;
        CFG_IDX_LESS: cmp_less_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // element products
  assign x       = in_data.elem_first[ELEM_BITS-1:0];
  assign y       = in_data.elem_second[ELEM_BITS-1:0];
  assign prod_xy = x * y;
  assign prod_xx = x * x;
  assign prod_yy = y * y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      prod_dot_r <= prod_xy;
      prod_na_r  <= prod_xx;
      prod_nb_r  <= prod_yy;
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.acc_clear) begin
      acc_dot_r <= '0;
      acc_na_r  <= '0;
      acc_nb_r  <= '0;
    end else if (prod_vld_r) begin
      acc_dot_r <= acc_dot_r + {{(ACC_W-PROD_W){prod_dot_r[PROD_W-1]}}, prod_dot_r};
      acc_na_r  <= acc_na_r + {{(ACC_W-PROD_W){prod_na_r[PROD_W-1]}}, prod_na_r};
      acc_nb_r  <= acc_nb_r + {{(ACC_W-PROD_W){prod_nb_r[PROD_W-1]}}, prod_nb_r};
    end
  end

  assign sts.zero_norm = acc_na_r[ACC_W-1] || (acc_na_r == '0) ||
                         acc_nb_r[ACC_W-1] || (acc_nb_r == '0);

  assign dot_mag = acc_dot_r[ACC_W-1] ? (~acc_dot_r + ACC_W'(1)) : acc_dot_r;
  assign den_sq  = ratio_den_r * ratio_den_r;
  assign num_sq  = ratio_num_r * ratio_num_r;

  // one limb product per cycle, row by row
  assign t_idx    = cmd.limb_i + LIMB_IW'(cmd.limb_j);
  assign a_limb   = mul_a_r[cmd.limb_i*LIMB_W +: LIMB_W];
  assign b_limb   = mul_b_r[cmd.limb_j*LIMB_W +: LIMB_W];
  assign t_limb   = mul_t_r[t_idx*LIMB_W +: LIMB_W];
  assign carry_in = cmd.row_start ? '0 : carry_r;
  assign cur      = (2*LIMB_W)'(a_limb) * (2*LIMB_W)'(b_limb) +
                    (2*LIMB_W)'(t_limb) + (2*LIMB_W)'(carry_in);

  always_comb begin
    mul_t_nxt = mul_t_r;
    mul_t_nxt[t_idx*LIMB_W +: LIMB_W] = cur[LIMB_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.op_load) begin
      mul_t_r <= '0;
      case (cmd.ld_sel)
        LD_DOT_SQ: begin
          mul_a_r <= MUL_W'(dot_mag);
          mul_b_r <= MULB_W'(dot_mag);
        end
        LD_LHS_K: begin
          mul_a_r <= mul_t_r;
          mul_b_r <= MULB_W'(den_sq);
        end
        LD_NORMS: begin
          lhs_r   <= mul_t_r;
          mul_a_r <= MUL_W'(acc_na_r);
          mul_b_r <= MULB_W'(acc_nb_r);
        end
        LD_RHS_K: begin
          mul_a_r <= mul_t_r;
          mul_b_r <= MULB_W'(num_sq);
        end
        default: ;
      endcase
    end else if (cmd.mul_en) begin
      mul_t_r <= mul_t_nxt;
      carry_r <= cur[2*LIMB_W-1:LIMB_W];
    end
  end

  // compare and output register
  assign lhs_gt = lhs_r > mul_t_r;
  assign lhs_lt = lhs_r < mul_t_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.zero_norm <= cmd.out_zero;
      if (cmd.out_zero) begin
        out_data_r.test_true <= cmp_less_r;
      end else begin
        out_data_r.test_true <= cmp_less_r ? lhs_lt : lhs_gt;
      end
    end
  end

  assign out_data = out_data_r;

endmodule
`default_nettype wire

>>> design/ctc_ctrl.sv
// controller: beat acceptance, multiply sequencing and output handshake
`default_nettype none
module ctc_ctrl import ctc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire ctc_sts_t sts,
  output ctc_cmd_t      cmd
);

  ctc_state_t         state_r, state_nxt;
  ld_sel_t            step_r, step_nxt;
  logic [LIMB_IW-1:0] i_r, i_nxt;
  logic [ROW_IW-1:0]  j_r, j_nxt;
  logic               zero_r, zero_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LIMB_IW-1:0] row_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      step_r      <= LD_DOT_SQ;
      i_r         <= '0;
      j_r         <= '0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // last limb of the current row, product truncated to the result width
  assign row_end = LIMB_IW'(LIMBS - 1) - LIMB_IW'(j_r);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    zero_nxt      = zero_r;
    cmd           = '0;
    cmd.ld_sel    = step_r;
    cmd.limb_i    = i_r;
    cmd.limb_j    = j_r;
    cmd.out_zero  = zero_r;
    in_stall      = 1'b1;

    case (state_r)
      ST_ACCUM: begin
        in_stall    = 1'b0;
        cmd.in_take = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        zero_nxt = sts.zero_norm;
        step_nxt = LD_DOT_SQ;
        if (sts.zero_norm) begin
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.op_load = 1'b1;
        i_nxt       = '0;
        j_nxt       = '0;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en    = 1'b1;
        cmd.row_start = (i_r == '0);
        if (i_r == row_end) begin
          i_nxt = '0;
          if (j_r == ROW_IW'(B_LIMBS - 1)) begin
            case (step_r)
              LD_DOT_SQ: begin
                step_nxt  = LD_LHS_K;
                state_nxt = ST_LOAD;
              end
              LD_LHS_K: begin
                step_nxt  = LD_NORMS;
                state_nxt = ST_LOAD;
              end
              LD_NORMS: begin
                step_nxt  = LD_RHS_K;
                state_nxt = ST_LOAD;
              end
              default: begin
                state_nxt = ST_RESULT;
              end
            endcase
          end else begin
            j_nxt = j_r + ROW_IW'(1);
          end
        end else begin
          i_nxt = i_r + LIMB_IW'(1);
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          cmd.acc_clear = 1'b1;
          state_nxt     = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> design/cosine_threshold_compare.sv
// top level: streaming cosine squared threshold test on two integer vectors
// throughput: one element pair per cycle while a vector streams in
// after the last pair the input stalls while one 32x32 limb multiplier runs
// four wide products (skipped when a norm is zero) before the result beat is
// loaded once the output register is free, then the next vector is taken at once
// reset: accumulators cleared, ratio 999/1000, greater mode, no result pending
`default_nettype none
module cosine_threshold_compare import ctc_pkg::*; #(
  parameter int ELEM_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_beat_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_beat_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  ctc_cmd_t cmd;
  ctc_sts_t sts;

  assign cfg_ready = 1'b1;

  ctc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_element),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ctc_datapath #(
    .ELEM_BITS (ELEM_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> bench/cosine_threshold_compare_test.sv
// self-checking bench for cosine_threshold_compare: directed and random vectors with a scoreboard
`timescale 1ns / 100ps
module cosine_threshold_compare_test;
  import ctc_pkg::*;

  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int DRAIN_CYCLES    = 80;
  localparam int SETTLE_LIMIT    = 20000;
  localparam int LONG_HOLD       = 400;
  localparam int RANDOM_PHASES   = 8;
  localparam int PAIRS_PER_PHASE = 112;
  localparam int TIMEOUT_NS      = 10_000_000;
  localparam int REPORT_CAP      = 50;

  localparam logic [CFG_IW-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;

  class cosine_scoreboard;
    logic [CFG_W-1:0] ratio_num;
    logic [CFG_W-1:0] ratio_den;
    logic less_mode;
    logic signed [ACC_W-1:0] dot_acc;
    logic signed [ACC_W-1:0] norm_a_acc;
    logic signed [ACC_W-1:0] norm_b_acc;
    out_beat_t pending[$];
    int mismatches;
    int results_seen;
    int zero_norm_seen;
    int held_seen;

    function new();
      ratio_num = NUM_RESET;
      ratio_den = DEN_RESET;
      less_mode = 1'b0;
      clear_sums();
    endfunction

    function void clear_sums();
      dot_acc = '0;
      norm_a_acc = '0;
      norm_b_acc = '0;
    endfunction

    function void write_register(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_IDX_NUM: ratio_num = value;
        CFG_IDX_DEN: ratio_den = value;
        CFG_IDX_LESS: less_mode = value[0];
        default: ;
      endcase
    endfunction

    function void note_pair(in_beat_t beat);
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] y;
      logic [ACC_W-1:0] mag;
      logic [255:0] lhs;
      logic [255:0] rhs;
      out_beat_t res;
      x = {{(ACC_W-ELEM_W){beat.elem_first[ELEM_W-1]}}, beat.elem_first};
      y = {{(ACC_W-ELEM_W){beat.elem_second[ELEM_W-1]}}, beat.elem_second};
      dot_acc = dot_acc + x * y;
      norm_a_acc = norm_a_acc + x * x;
      norm_b_acc = norm_b_acc + y * y;
      if (!beat.last_element) return;
      res.zero_norm = (norm_a_acc <= 0) || (norm_b_acc <= 0);
      if (res.zero_norm) begin
        res.test_true = less_mode;
      end else begin
        mag = dot_acc[ACC_W-1] ? -dot_acc : dot_acc;
        lhs = 256'(mag) * 256'(mag) * 256'(ratio_den) * 256'(ratio_den);
        rhs = 256'(norm_a_acc) * 256'(norm_b_acc) * 256'(ratio_num) * 256'(ratio_num);
        res.test_true = less_mode ? (lhs < rhs) : (lhs > rhs);
      end
      pending.push_back(res);
      clear_sums();
    endfunction

    task report_mismatch(string what);
      if (mismatches < REPORT_CAP) $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(out_beat_t got);
      out_beat_t want;
      results_seen++;
      if (got.zero_norm === 1'b1) zero_norm_seen++;
      if (got.test_true === 1'b1) held_seen++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no vector pending", results_seen));
        return;
      end
      want = pending.pop_front();
      if (got.test_true !== want.test_true)
        report_mismatch($sformatf("result %0d test_true %b, expected %b",
                                  results_seen, got.test_true, want.test_true));
      if (got.zero_norm !== want.zero_norm)
        report_mismatch($sformatf("result %0d zero_norm %b, expected %b",
                                  results_seen, got.zero_norm, want.zero_norm));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  out_beat_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  cosine_scoreboard board;
  bit sender_burst;
  bit recv_burst;
  bit long_hold_pending;
  int pairs_sent;
  int vectors_sent;
  int settings_used;

  cosine_threshold_compare dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  task automatic send_pair(input logic signed [ELEM_W-1:0] a, input logic signed [ELEM_W-1:0] b,
                           input logic last);
    int gap;
    in_beat_t beat;
    gap = sender_burst ? 0 : $urandom_range(0, 9);
    beat.elem_first = a;
    beat.elem_second = b;
    beat.last_element = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_pair(beat);
    pairs_sent++;
  endtask

  task automatic send_vector();
    int len;
    int mode;
    int noise;
    int k;
    bit zero_first;
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    mode = $urandom_range(0, 9);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    zero_first = $urandom_range(0, 1);
    for (k = 0; k < len; k++) begin
      noise = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 6)) - 3;
      a = $urandom;
      b = $urandom;
      case (mode)
        0, 1, 2: ;
        3, 4: begin
          a = $urandom_range(0, 16) - 8;
          b = $urandom_range(0, 16) - 8;
        end
        5, 6: begin
          a = a >>> $urandom_range(0, ELEM_W - 1);
          b = a + noise;
        end
        7, 8: begin
          a = a >>> $urandom_range(0, ELEM_W - 1);
          b = -a + noise;
        end
        default: begin
          if (zero_first) a = '0;
          else b = '0;
        end
      endcase
      send_pair(a, b, k == len - 1);
    end
    vectors_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    board.write_register(idx, value);
    @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_W-1:0] num, input logic [CFG_W-1:0] den,
                               input logic less);
    write_reg(CFG_IDX_NUM, num);
    write_reg(CFG_IDX_DEN, den);
    write_reg(CFG_IDX_LESS, {15'($urandom), less});
    write_reg(CFG_IDX_SPARE, 16'($urandom));
    settings_used++;
  endtask

  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (board.pending.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_pending) begin
        hold = LONG_HOLD;
        long_hold_pending = 1'b0;
      end else begin
        hold = recv_burst ? 0 : $urandom_range(0, 9);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      board.check_result(out_data);
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d results outstanding", board.pending.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int phase;
    int quota;
    logic [CFG_W-1:0] num;
    logic [CFG_W-1:0] den;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset ratio 999/1000, greater mode
    send_pair(ELEM_MAX, ELEM_MAX, 1'b1);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b0);
    send_pair(0, -1, 1'b0);
    send_pair(-1, 0, 1'b1);
    send_pair(0, 5, 1'b0);
    send_pair(0, -7, 1'b1);
    send_pair(3, 0, 1'b1);
    send_pair(0, 0, 1'b1);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b0);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
    send_pair(1, 0, 1'b0);
    send_pair(0, 1, 1'b1);
    settle();

    // exact tie in both modes
    write_setting(16'd1, 16'd1, 1'b0);
    send_pair(3, 3, 1'b0);
    send_pair(-4, -4, 1'b1);
    settle();
    write_setting(16'd1, 16'd1, 1'b1);
    send_pair(3, 3, 1'b0);
    send_pair(-4, -4, 1'b1);
    send_pair(0, 0, 1'b1);
    settle();

    // zero denominator, then zero numerator too
    write_setting(16'd1, 16'd0, 1'b1);
    send_pair(5, 2, 1'b0);
    send_pair(1, 7, 1'b1);
    settle();
    write_setting(16'd0, 16'd0, 1'b0);
    send_pair(2, 9, 1'b1);
    settle();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      sender_burst = (phase % 4 == 3);
      recv_burst = (phase % 4 == 3);
      case (phase)
        0: write_setting(16'd0, 16'hFFFF, 1'b0);
        1: write_setting(16'hFFFF, 16'd1, 1'b1);
        2: write_setting(16'hFFFF, 16'hFFFF, 1'b0);
        default: begin
          den = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
          num = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, den)) :
                den - 16'($urandom_range(0, den / 64));
          write_setting(num, den, 1'($urandom_range(0, 1)));
        end
      endcase
      long_hold_pending = (phase == 2);
      quota = pairs_sent + PAIRS_PER_PHASE;
      while (pairs_sent < quota) send_vector();
      settle();
    end

    if (board.pending.size() != 0)
      board.report_mismatch($sformatf("%0d expected results never arrived",
                                      board.pending.size()));
    $display("sent %0d element pairs (%0d random vectors) under %0d register settings",
             pairs_sent, vectors_sent, settings_used);
    $display("checked %0d results: %0d with zero norm, %0d where the test held",
             board.results_seen, board.zero_norm_seen, board.held_seen);
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> cosine_threshold_compare.f
design/ctc_pkg.sv
design/ctc_datapath.sv
design/ctc_ctrl.sv
design/cosine_threshold_compare.sv
bench/cosine_threshold_compare_test.sv
